>>> sv/lpc_pkg.sv
package lpc_pkg;

  // Default store depth, in letters
  localparam int unsigned DEPTH_DEF = 128;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned CODE_W = 5;
  localparam int unsigned KEPT_W = 8;

  localparam logic [CHAR_W-1:0] CH_UPPER_FIRST = 8'h41;  // 'A'
  localparam logic [CHAR_W-1:0] CH_UPPER_LAST  = 8'h5A;  // 'Z'
  localparam logic [CHAR_W-1:0] CH_LOWER_FIRST = 8'h61;  // 'a'
  localparam logic [CHAR_W-1:0] CH_LOWER_LAST  = 8'h7A;  // 'z'

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_WALK,
    ST_DONE
  } lpc_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;  // input byte transfer this cycle
    logic start;   // final byte transferred, set up the walk
    logic issue;   // read one pair from both ends of the store
    logic push;    // load the result register, clear the string state
  } lpc_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic more;    // pairs left to read
  } lpc_sts_t;

endpackage

>>> sv/lpc_in_if.sv
interface lpc_in_if
  import lpc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_in;
  logic              last;

  modport source (output valid, output char_in, output last, input ready);
  modport sink   (input valid, input char_in, input last, output ready);
endinterface

>>> sv/lpc_out_if.sv
interface lpc_out_if
  import lpc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              is_palindrome;
  logic              overflow;
  logic [KEPT_W-1:0] letters_kept;

  modport source (output valid, output is_palindrome, output overflow,
                  output letters_kept, input ready);
  modport sink   (input valid, input is_palindrome, input overflow,
                  input letters_kept, output ready);
endinterface

>>> sv/lpc_ctrl.sv
module lpc_ctrl
  import lpc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_last_i,
  output logic     in_ready_o,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  input  lpc_sts_t sts_i,
  output lpc_cmd_t cmd_o
);

  lpc_state_e state_q, state_d;
  logic       out_vld_q, out_vld_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    out_vld_d  = out_vld_q & ~out_ready_i;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && in_last_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_WALK;
        end
      end
      ST_WALK: begin
        if (sts_i.more) begin
          cmd_o.issue = 1'b1;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // result register free or being emptied this cycle
        if (!out_vld_q || out_ready_i) begin
          cmd_o.push = 1'b1;
          out_vld_d  = 1'b1;
          state_d    = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  assign out_valid_o = out_vld_q;

endmodule

>>> sv/lpc_dpath.sv
module lpc_dpath
  import lpc_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lpc_cmd_t          cmd_i,
  input  logic [CHAR_W-1:0] char_i,
  output lpc_sts_t          sts_o,
  output logic              is_pal_o,
  output logic              ovf_o,
  output logic [KEPT_W-1:0] kept_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CODE_W-1:0] mem_q [DEPTH];

  logic [CW-1:0]     count_q, count_d;
  logic              ovf_q, ovf_d;
  logic [CW-1:0]     lo_q, lo_d;
  logic [CW-1:0]     end_q, end_d;   // one past the upper read index
  logic              cmp_vld_q;
  logic              mismatch_q, mismatch_d;
  logic [CODE_W-1:0] rd_a_q, rd_b_q;
  logic              pal_res_q, ovf_res_q;
  logic [KEPT_W-1:0] kept_res_q;

  logic              is_upper, is_lower, is_letter, wr_en;
  logic [CODE_W-1:0] code;
  logic [AW-1:0]     addr_a, addr_b;
  logic [CW-1:0]     end_m1;
  logic [CW+KEPT_W-1:0] count_ext;

  assign is_upper  = (char_i >= CH_UPPER_FIRST) && (char_i <= CH_UPPER_LAST);
  assign is_lower  = (char_i >= CH_LOWER_FIRST) && (char_i <= CH_LOWER_LAST);
  assign is_letter = is_upper | is_lower;
  // case fold: both cases map to 0..25
  assign code = is_upper ? CODE_W'(char_i - CH_UPPER_FIRST)
                         : CODE_W'(char_i - CH_LOWER_FIRST);

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    wr_en   = 1'b0;
    if (cmd_i.push) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end else if (cmd_i.accept && is_letter) begin
      if (count_q < CW'(DEPTH)) begin
        wr_en   = 1'b1;
        count_d = count_q + CW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  assign end_m1 = end_q - CW'(1);
  assign addr_a = lo_q[AW-1:0];
  assign addr_b = end_m1[AW-1:0];

  always_comb begin
    lo_d       = lo_q;
    end_d      = end_q;
    mismatch_d = mismatch_q;
    if (cmd_i.start) begin
      lo_d       = '0;
      end_d      = count_d;
      mismatch_d = 1'b0;
    end else begin
      if (cmd_i.issue) begin
        lo_d  = lo_q + CW'(1);
        end_d = end_m1;
      end
      if (cmp_vld_q && (rd_a_q != rd_b_q)) begin
        mismatch_d = 1'b1;
      end
    end
  end

  // lo < hi, with hi = end - 1
  assign sts_o.more = (lo_q + CW'(1)) < end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      ovf_q      <= 1'b0;
      lo_q       <= '0;
      end_q      <= '0;
      cmp_vld_q  <= 1'b0;
      mismatch_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      ovf_q      <= ovf_d;
      lo_q       <= lo_d;
      end_q      <= end_d;
      cmp_vld_q  <= cmd_i.issue;
      mismatch_q <= mismatch_d;
    end
  end

  // letter store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[count_q[AW-1:0]] <= code;
    end
    if (cmd_i.issue) begin
      rd_a_q <= mem_q[addr_a];
      rd_b_q <= mem_q[addr_b];
    end
  end

  assign count_ext = {{KEPT_W{1'b0}}, count_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      pal_res_q  <= ~mismatch_q;
      ovf_res_q  <= ovf_q;
      kept_res_q <= count_ext[KEPT_W-1:0];
    end
  end

  assign is_pal_o = pal_res_q;
  assign ovf_o    = ovf_res_q;
  assign kept_o   = kept_res_q;

endmodule

>>> sv/letter_palindrome_checker_unit.sv
// Letter palindrome checker.
// Input channel in_i: one byte per transfer (char_in), last marks the final
// byte of a string. Non-letters are skipped; letters are case folded and kept
// in a DEPTH-entry store, extras beyond DEPTH are dropped and flagged.
// Output channel out_o: one transfer per string with is_palindrome, overflow
// and letters_kept (low 8 bits of the kept count). An empty string is a
// palindrome.
// Throughput: one byte per cycle while a string loads. After the final byte
// the store is walked from both ends, one pair a cycle over its two read
// ports, with in_i.ready low, and the result is registered when it ends.
// The result sits in an output register: loading of the next string goes on
// while it waits. If out_o is still stalled when the next walk finishes, the
// block holds (in_i.ready low) until the register frees.
// Reset (rst_ni, async, active low) empties the string state and the output
// register; the letter store is not cleared, only written entries are read.
module letter_palindrome_checker_unit
  import lpc_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lpc_in_if.sink    in_i,
  lpc_out_if.source out_o
);

  lpc_cmd_t cmd;
  lpc_sts_t sts;

  // Sequencer: load, walk, hand over result
  lpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.last),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Store, walk pointers, compare and result register
  lpc_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .char_i   (in_i.char_in),
    .sts_o    (sts),
    .is_pal_o (out_o.is_palindrome),
    .ovf_o    (out_o.overflow),
    .kept_o   (out_o.letters_kept)
  );

`ifndef SYNTH
  // The final byte always starts a walk, so no byte is taken right after it.
  a_walk_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.last) |=> !in_i.ready)
    else $error("byte accepted right after end of string");

  // A new result only shows up out of the walk, never during loading.
  a_result_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(!in_i.ready))
    else $error("result produced while loading");

  // Dropped letters mean the store was full.
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.overflow) |-> (out_o.letters_kept == KEPT_W'(DEPTH)))
    else $error("overflow flagged with store not full");
`endif

endmodule

>>> bench/letter_palindrome_checker_unit_tb.sv
module letter_palindrome_checker_unit_tb;
  import lpc_pkg::*;

  // Run-length knobs
  localparam int unsigned ITEMS_TOTAL  = 700;
  localparam int unsigned N_PHASES     = 4;
  localparam int unsigned HOLD_CYCLES  = 400;
  // Drain a bit longer than the worst walk at the end
  localparam int unsigned DRAIN_CYCLES = DEPTH_DEF / 2 + 8;
  // Hard limit in time units, far above the slowest legal run
  localparam int unsigned LIMIT_TICKS  = 2_000_000;

  localparam logic [CHAR_W-1:0] CASE_GAP = 8'd32;
  localparam int unsigned       N_ALPHA  = 26;

  // One result transfer, as predicted or as seen on out_o
  typedef struct packed {
    logic              is_palindrome;
    logic              overflow;
    logic [KEPT_W-1:0] letters_kept;
  } verdict_t;

  // Shapes of generated strings
  typedef enum int {
    K_MIRROR,    // letters read the same both ways
    K_NEAR,      // mirror with one letter spoiled
    K_SCRAMBLE,  // random letters
    K_NOISE      // raw random bytes, letters or not
  } string_kind_e;

  // ---------------------------------------------------------------------------
  // Scoreboard: predicts a verdict from every accepted byte, holds the
  // verdicts in order and checks each result transfer against the oldest.
  // ---------------------------------------------------------------------------
  class palindrome_scoreboard;
    logic [CODE_W-1:0] letter_codes [DEPTH_DEF];
    int unsigned       kept_cnt;
    bit                dropped;
    verdict_t          verdict_q[$];
    int unsigned       errors;
    int unsigned       strings_seen;
    int unsigned       palindromes_seen;
    int unsigned       overflows_seen;
    int unsigned       longest_kept;

    function new();
      kept_cnt         = 0;
      dropped          = 0;
      errors           = 0;
      strings_seen     = 0;
      palindromes_seen = 0;
      overflows_seen   = 0;
      longest_kept     = 0;
    endfunction

    task report(input string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    function void note_input(input logic [CHAR_W-1:0] ch, input logic fin);
      logic              up;
      logic              low;
      logic [CHAR_W-1:0] folded;
      logic              pal;
      int unsigned       lo;
      int unsigned       hi;
      verdict_t          v;
      up  = (ch >= CH_UPPER_FIRST) && (ch <= CH_UPPER_LAST);
      low = (ch >= CH_LOWER_FIRST) && (ch <= CH_LOWER_LAST);
      if (up || low) begin
        folded = up ? ch + CASE_GAP : ch;
        if (kept_cnt < DEPTH_DEF) begin
          letter_codes[kept_cnt] = CODE_W'(folded - CH_LOWER_FIRST);
          kept_cnt++;
        end else begin
          dropped = 1'b1;
        end
      end
      if (fin) begin
        pal = 1'b1;
        if (kept_cnt > 1) begin
          lo = 0;
          hi = kept_cnt - 1;
          while (lo < hi) begin
            if (letter_codes[lo] != letter_codes[hi]) begin
              pal = 1'b0;
              break;
            end
            lo++;
            hi--;
          end
        end
        v.is_palindrome = pal;
        v.overflow      = dropped;
        v.letters_kept  = KEPT_W'(kept_cnt);
        verdict_q.push_back(v);
        if (kept_cnt > longest_kept) longest_kept = kept_cnt;
        kept_cnt = 0;
        dropped  = 1'b0;
      end
    endfunction

    task check_result(input verdict_t got);
      verdict_t want;
      if (verdict_q.size() == 0) begin
        report($sformatf("unexpected result pal=%0b ovf=%0b kept=%0d",
                         got.is_palindrome, got.overflow, got.letters_kept));
      end else begin
        want = verdict_q.pop_front();
        strings_seen++;
        if (want.is_palindrome) palindromes_seen++;
        if (want.overflow) overflows_seen++;
        if (got.is_palindrome !== want.is_palindrome)
          report($sformatf("string %0d is_palindrome got %0b want %0b",
                           strings_seen, got.is_palindrome, want.is_palindrome));
        if (got.overflow !== want.overflow)
          report($sformatf("string %0d overflow got %0b want %0b",
                           strings_seen, got.overflow, want.overflow));
        if (got.letters_kept !== want.letters_kept)
          report($sformatf("string %0d letters_kept got %0d want %0d",
                           strings_seen, got.letters_kept, want.letters_kept));
      end
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset, channels, DUT
  // ---------------------------------------------------------------------------
  logic clk_i;
  logic rst_ni;

  lpc_in_if  in_if();
  lpc_out_if out_if();

  letter_palindrome_checker_unit #(
    .DEPTH (DEPTH_DEF)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  palindrome_scoreboard sb = new();

  // Idle knobs, set by the stimulus between strings
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  // Long receiver hold-off: stimulus bumps hold_req, receiver counts it out
  int unsigned hold_req;
  int unsigned hold_seen;
  int unsigned hold_left;
  int unsigned bytes_sent;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop, well beyond any correct run
  initial begin
    #(LIMIT_TICKS);
    $display("TIMEOUT: run did not drain");
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready changes at the falling edge only. Random stalls follow
  // recv_stall_pct; a hold request forces ready low while hold_left counts down
  // from HOLD_CYCLES, so the output register fills and the block backs up into in_i.
  // ---------------------------------------------------------------------------
  initial begin
    out_if.ready = 1'b0;
    hold_seen    = 0;
    hold_left    = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Result monitor: a transfer is valid && ready at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_result('{out_if.is_palindrome, out_if.overflow, out_if.letters_kept});
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // One byte transfer. Gaps are spent with valid low and junk on the payload.
  task automatic send_byte(input logic [CHAR_W-1:0] ch, input logic fin);
    @(negedge clk_i);
    while ($urandom_range(99) < send_gap_pct) begin
      in_if.valid   <= 1'b0;
      in_if.char_in <= CHAR_W'($urandom);
      in_if.last    <= 1'($urandom);
      @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.char_in <= ch;
    in_if.last    <= fin;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(ch, fin);
    bytes_sent++;
  endtask

  task automatic send_string(input logic [CHAR_W-1:0] text[$]);
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
  endtask

  // Any byte that is not an ASCII letter
  function automatic logic [CHAR_W-1:0] noise_byte();
    logic [CHAR_W-1:0] b;
    do begin
      b = CHAR_W'($urandom_range(255));
    end while ((b >= CH_UPPER_FIRST && b <= CH_UPPER_LAST) ||
               (b >= CH_LOWER_FIRST && b <= CH_LOWER_LAST));
    return b;
  endfunction

  // Build a string of n_letters letters of the given shape (K_NOISE: raw bytes),
  // in random case, with non-letters sprinkled in when noisy is set. Beyond DEPTH
  // letters the mirror covers only the kept part; the dropped tail is random.
  function automatic void build_string(input string_kind_e kind,
                                       input int unsigned n_letters,
                                       input bit noisy,
                                       output logic [CHAR_W-1:0] text[$]);
    int unsigned codes [$];
    int unsigned m;
    int unsigned idx;
    int unsigned nn;
    text = {};
    if (kind == K_NOISE) begin
      nn = $urandom_range(8, 1);
      repeat (nn) text.push_back(CHAR_W'($urandom_range(255)));
      return;
    end
    m = (n_letters > DEPTH_DEF) ? DEPTH_DEF : n_letters;
    for (int unsigned i = 0; i < n_letters; i++) codes.push_back($urandom_range(N_ALPHA - 1));
    if (kind != K_SCRAMBLE) begin
      for (int unsigned i = 0; i < m / 2; i++) codes[m - 1 - i] = codes[i];
      if (kind == K_NEAR && m >= 2) begin
        idx = $urandom_range(m / 2 - 1);
        codes[idx] = (codes[idx] + 1 + $urandom_range(N_ALPHA - 2)) % N_ALPHA;
      end
    end
    foreach (codes[i]) begin
      if (noisy && $urandom_range(99) < 20) begin
        nn = $urandom_range(2, 1);
        repeat (nn) text.push_back(noise_byte());
      end
      text.push_back(($urandom_range(1) ? CH_UPPER_FIRST : CH_LOWER_FIRST) +
                     CHAR_W'(codes[i]));
    end
    // Sometimes the final byte is a non-letter
    if (text.size() == 0 || (noisy && $urandom_range(99) < 30)) text.push_back(noise_byte());
  endfunction

  task automatic send_random_string();
    logic [CHAR_W-1:0] text[$];
    int unsigned       pick;
    int unsigned       n;
    string_kind_e      kind;
    pick = $urandom_range(99);
    if (pick < 45)      kind = K_MIRROR;
    else if (pick < 65) kind = K_NEAR;
    else if (pick < 85) kind = K_SCRAMBLE;
    else                kind = K_NOISE;
    // Mostly short strings; now and then one close to, at or past the store depth
    n = ($urandom_range(99) < 3) ? $urandom_range(DEPTH_DEF + 12, DEPTH_DEF - 8)
                                 : $urandom_range(12);
    build_string(kind, n, $urandom_range(99) < 60, text);
    send_string(text);
  endtask

  // ---------------------------------------------------------------------------
  // Main stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [CHAR_W-1:0] text[$];
    int unsigned       phase_base;
    int unsigned       phase_span;

    in_if.valid    = 1'b0;
    in_if.char_in  = '0;
    in_if.last     = 1'b0;
    rst_ni         = 1'b0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_req       = 0;
    bytes_sent     = 0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed strings: empty, single letter, the bytes on both sides of
    // each letter range, case folding, non-letters with the top bit set.
    send_string('{8'h00});                                        // empty
    send_string('{8'h41});                                        // single letter
    send_string('{8'h40, 8'h41, 8'h7A, 8'h5B,
                  8'h60, 8'h5A, 8'h61, 8'h7B});                   // "@Az[`Za{"
    send_string('{8'h41, 8'h62});                                 // "Ab", not one
    send_string('{8'h61, 8'hFF, 8'h42, 8'h80, 8'h41});            // "a?B?A"
    send_string('{8'h5A, 8'h7A});                                 // "Zz"
    send_string('{8'hFF});                                        // empty, all ones

    // Store exactly full, then overflowing, both ending on a letter
    build_string(K_MIRROR, DEPTH_DEF, 1'b0, text);
    send_string(text);
    build_string(K_MIRROR, DEPTH_DEF + 3, 1'b0, text);
    send_string(text);

    // Random phases share what is left of the byte budget evenly
    phase_base = bytes_sent;
    phase_span = (ITEMS_TOTAL > phase_base) ? ITEMS_TOTAL - phase_base : N_PHASES * 40;

    // Random phases: no idling, sender gaps, receiver stalls, both.
    for (int unsigned ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 53; recv_stall_pct = 0;  end
        2: begin
          send_gap_pct   = 0;
          recv_stall_pct = 53;
          // Long hold-off while bytes keep coming: fills the output register
          hold_req++;
        end
        default: begin send_gap_pct = 19; recv_stall_pct = 19; end
      endcase
      while (bytes_sent < phase_base + (ph + 1) * phase_span / N_PHASES)
        send_random_string();
    end

    @(negedge clk_i);
    in_if.valid <= 1'b0;

    // Drain: every verdict must come back, then give the walk time to
    // show any stray result.
    while (sb.verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.verdict_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.verdict_q.size()));

    $display("Covered %0d bytes in %0d strings: %0d palindromes, %0d overflowed,",
             bytes_sent, sb.strings_seen, sb.palindromes_seen, sb.overflows_seen);
    $display("longest kept %0d letters, under gaps, stalls and a long output hold-off.",
             sb.longest_kept);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> letter_palindrome_checker_unit.f
sv/lpc_pkg.sv
sv/lpc_in_if.sv
sv/lpc_out_if.sv
sv/lpc_ctrl.sv
sv/lpc_dpath.sv
sv/letter_palindrome_checker_unit.sv
bench/letter_palindrome_checker_unit_tb.sv
